// ===== rtl/emod_pkg.sv =====
// Package for the echo median occupancy debounce block.
// Holds widths, register indexes, payload structs and cell link types.
// No dependencies; every rtl file refers to it by scoped names.
package emod_pkg;

   localparam int MAX_SAMPLES = 5;
   localparam int US_W        = 16;
   localparam int DIST_W      = 15;
   localparam int DEB_W       = 8;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int CELL_IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int MC_W        = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int PROD_W      = US_W + DIST_W;

   localparam logic [DIST_W-1:0] TIMEOUT_Q4 = DIST_W'(15984);
   localparam logic [DIST_W-1:0] SCALE_Q16  = DIST_W'(17983);

   localparam logic [CSR_IDX_W-1:0] REG_MEDIAN_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_Q4   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_COUNT = CSR_IDX_W'(2);

   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic            command;
      logic [US_W-1:0] echo_us;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_q4;
      logic              raw_occupied;
      logic              stable_occupied;
   } rsp_type;

   // Data handed from one cell of the sorted chain to the next.
   typedef struct packed {
      logic [DIST_W-1:0] value;
      logic              above;
   } link_type;

   typedef struct packed {
      logic restart;
      logic update;
      logic raw;
   } deb_ctrl_type;

endpackage

// ===== rtl/emod_cell.sv =====
// One cell of the sorted insertion chain.
// Depends on emod_pkg for the link type and distance width.
module emod_cell (
   input  logic                       clock,
   input  logic                       load,
   input  logic [emod_pkg::DIST_W-1:0] sample,
   input  logic                       occupied,
   input  emod_pkg::link_type         left,
   output emod_pkg::link_type         right
);

   logic [emod_pkg::DIST_W-1:0] value_ff;
   logic [emod_pkg::DIST_W-1:0] value_in;
   logic                        above;

   // An empty cell counts as holding an infinite value.
   assign above = !occupied || (sample < value_ff);

   always_comb begin
      value_in = value_ff;
      if (load && above) begin
         value_in = left.above ? left.value : sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign right.value = value_ff;
   assign right.above = above;

endmodule

// ===== rtl/emod_debounce.sv =====
// Counting debouncer that turns raw occupancy into stable occupancy.
// Depends on emod_pkg for the control struct and counter width.
module emod_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  emod_pkg::deb_ctrl_type    ctrl,
   input  logic [emod_pkg::DEB_W-1:0] need,
   output logic                      stable
);

   logic                       started_ff, started_in;
   logic                       stable_ff, stable_in;
   logic                       pending_ff, pending_in;
   logic [emod_pkg::DEB_W-1:0] count_ff, count_in;

   always_comb begin
      started_in = started_ff;
      stable_in  = stable_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      if (need <= emod_pkg::DEB_W'(1) || !started_ff) begin
         started_in = 1'b1;
         stable_in  = ctrl.raw;
         pending_in = ctrl.raw;
         count_in   = '0;
      end else if (ctrl.raw == stable_ff) begin
         pending_in = ctrl.raw;
         count_in   = '0;
      end else begin
         if (ctrl.raw != pending_ff) begin
            pending_in = ctrl.raw;
            count_in   = emod_pkg::DEB_W'(1);
         end else if (count_ff < need) begin
            count_in = count_ff + emod_pkg::DEB_W'(1);
         end
         if (count_in >= need) begin
            stable_in = ctrl.raw;
            count_in  = '0;
         end
      end
   end

   assign stable = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         stable_ff  <= 1'b0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
      end else if (ctrl.update) begin
         started_ff <= started_in;
         stable_ff  <= stable_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end else if (ctrl.restart) begin
         started_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   // After an update the pending run sits below the count that flips the state, or is empty.
   a_count_below_need: assert property (@(posedge clock) disable iff (reset)
      ctrl.update |=> (count_ff < $past(need) || count_ff == '0))
      else $error("pending count reached the debounce count without a flip");
   // A restart leaves the debouncer waiting for its first reading.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (ctrl.restart && !ctrl.update) |=> !started_ff)
      else $error("restart did not clear started");
   // Right after an update the debouncer has always started.
   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      ctrl.update |=> started_ff)
      else $error("update left the debouncer unstarted");
`endif

endmodule

// ===== rtl/echo_median_occupancy_debounce.sv =====
// Echo median occupancy debounce: top level.
// Depends on emod_pkg, emod_cell (sorted chain) and emod_debounce.
//
// Takes echo lengths in microseconds, converts each to a distance in 1/16 cm
// ((us*17983)>>16, timeout -> 15984), gathers median_count distances in a
// chain of MAX_SAMPLES sorting cells that keep the batch in ascending order
// as words arrive, and on the closing word emits the median (entry held/2),
// its raw occupancy (0 < distance < threshold_q4) and the debounced
// occupancy. A restart command clears the batch and the debouncer's start
// flag and emits nothing. A word is accepted, converted through the single
// 16x15 multiplier and inserted into the chain; a word that closes a batch
// then picks the median and runs the debouncer. The next word is taken only
// once the last one is through. A finished response waits in the output
// register while the next word is accepted; the block stalls only when a
// new response is ready and the old one has not been taken. Register writes
// go through csr_write/csr_index/csr_data and are meant only while the block
// is idle.
module echo_median_occupancy_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  emod_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output emod_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [emod_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [emod_pkg::CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_INSERT,
      S_EVAL
   } state_type;

   localparam int MAXS  = emod_pkg::MAX_SAMPLES;
   localparam int CNT_W = emod_pkg::CNT_W;
   localparam int DW    = emod_pkg::DIST_W;

   state_type state_ff;

   // Configuration registers.
   logic [emod_pkg::MC_W-1:0]  median_count_ff;
   logic [DW-1:0]              threshold_ff;
   logic [emod_pkg::DEB_W-1:0] debounce_count_ff;

   // Accepted word and its distance.
   logic                       cmd_ff;
   logic [emod_pkg::US_W-1:0]  echo_ff;
   logic [DW-1:0]              dist_ff;
   logic [emod_pkg::PROD_W-1:0] product;
   logic [DW-1:0]              dist_in;

   // Batch bookkeeping.
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_base;
   logic [CNT_W-1:0] fill_next;
   logic [CNT_W-1:0] n_eff;
   logic             pass_ff;

   // Sorting chain.
   emod_pkg::link_type         links [MAXS+1];
   logic [DW-1:0]              cell_value [MAXS];
   logic [MAXS-1:0]            cell_occupied;
   logic                       chain_load;
   logic [emod_pkg::CELL_IDX_W-1:0] med_idx;

   // Evaluation.
   logic [DW-1:0]              median;
   logic                       raw;
   logic                       can_emit;
   emod_pkg::deb_ctrl_type     deb_ctrl;
   logic                       stable;

   emod_pkg::rsp_type          rsp_ff;
   logic                       rsp_valid_ff;

   // Hold the register file; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         median_count_ff   <= emod_pkg::MC_W'(3);
         threshold_ff      <= DW'(800);
         debounce_count_ff <= emod_pkg::DEB_W'(3);
      end else if (csr_write) begin
         case (csr_index)
            emod_pkg::REG_MEDIAN_COUNT:   median_count_ff   <= csr_data[emod_pkg::MC_W-1:0];
            emod_pkg::REG_THRESHOLD_Q4:   threshold_ff      <= csr_data[DW-1:0];
            emod_pkg::REG_DEBOUNCE_COUNT: debounce_count_ff <= csr_data[emod_pkg::DEB_W-1:0];
            default: ;
         endcase
      end
   end

   // Convert microseconds to 1/16 cm; a zero length is the timeout sentinel.
   assign product = emod_pkg::PROD_W'(echo_ff) * emod_pkg::PROD_W'(emod_pkg::SCALE_Q16);
   assign dist_in = (echo_ff == '0) ? emod_pkg::TIMEOUT_Q4
                                    : product[emod_pkg::PROD_W-1:emod_pkg::US_W];

   // Clamp the batch size to the chain length.
   assign n_eff = (32'(median_count_ff) > MAXS) ? CNT_W'(MAXS) : CNT_W'(median_count_ff);

   assign fill_base = (32'(fill_ff) >= MAXS) ? '0 : fill_ff;
   assign fill_next = fill_base + CNT_W'(1);

   assign chain_load = (state_ff == S_INSERT) && (cmd_ff == emod_pkg::CMD_SAMPLE)
                       && (n_eff > CNT_W'(1));

   // Head of the chain: nothing to its left shifts in.
   assign links[0].value = '0;
   assign links[0].above = 1'b0;

   for (genvar i = 0; i < MAXS; i++) begin : g_cell
      assign cell_occupied[i] = CNT_W'(i) < fill_base;

      emod_cell u_cell (
         .clock    (clock),
         .load     (chain_load),
         .sample   (dist_ff),
         .occupied (cell_occupied[i]),
         .left     (links[i]),
         .right    (links[i+1])
      );

      assign cell_value[i] = links[i+1].value;
   end

   // The median sits at index held/2 of the sorted chain.
   assign med_idx = emod_pkg::CELL_IDX_W'(fill_ff >> 1);
   assign median  = pass_ff ? dist_ff : cell_value[med_idx];
   assign raw     = (median != '0) && (median < threshold_ff);

   assign can_emit = !rsp_valid_ff || rsp_ready;

   assign deb_ctrl.restart = (state_ff == S_INSERT) && (cmd_ff == emod_pkg::CMD_RESTART);
   assign deb_ctrl.update  = (state_ff == S_EVAL) && can_emit;
   assign deb_ctrl.raw     = raw;

   emod_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (deb_ctrl),
      .need   (debounce_count_ff),
      .stable (stable)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise valid when a new response is loaded; drop it once it is taken.
         if (state_ff == S_EVAL && can_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_data.command;
                  echo_ff  <= req_data.echo_us;
                  state_ff <= S_CONV;
               end
            end
            S_CONV: begin
               dist_ff  <= dist_in;
               state_ff <= S_INSERT;
            end
            S_INSERT: begin
               if (cmd_ff == emod_pkg::CMD_RESTART) begin
                  fill_ff  <= '0;
                  state_ff <= S_IDLE;
               end else if (n_eff <= CNT_W'(1)) begin
                  fill_ff  <= '0;
                  pass_ff  <= 1'b1;
                  state_ff <= S_EVAL;
               end else begin
                  fill_ff  <= fill_next;
                  pass_ff  <= 1'b0;
                  state_ff <= (fill_next >= n_eff) ? S_EVAL : S_IDLE;
               end
            end
            S_EVAL: begin
               // Advance only when the output register is free.
               if (can_emit) begin
                  rsp_ff.distance_q4     <= median;
                  rsp_ff.raw_occupied    <= raw;
                  rsp_ff.stable_occupied <= stable;
                  fill_ff                <= '0;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Between words a batch is never full: it closes as soon as it fills.
   a_idle_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (32'(fill_ff) < MAXS))
      else $error("batch left full while idle");
   // The first two entries of the chain stay in ascending order whenever both are held.
   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
      else $error("sorting chain out of order");
   // A restart word empties the batch and produces no response.
   a_restart_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT && cmd_ff == emod_pkg::CMD_RESTART)
      |=> (fill_ff == '0 && state_ff == S_IDLE))
      else $error("restart did not empty the batch");
   // A zero distance is never reported as occupied.
   a_zero_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.raw_occupied && rsp_ff.distance_q4 == '0))
      else $error("zero distance flagged occupied");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for echo_median_occupancy_debounce: random and directed echo words,
// a scoreboard that predicts the median/occupancy readings, and random idling.
// Depends on emod_pkg and the echo_median_occupancy_debounce RTL.
module tb;
   import emod_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE       = 16;     // drain margin after the last expected reading
   localparam int TARGET_WORDS = 1450;
   localparam int DIST_SCALE   = 17983;  // 0.0343/2 cm per us, in Q16 of 1/16 cm

   // Scoreboard: shadow copy of the block's state and a queue of expected readings
   class occupancy_scoreboard;
      logic [MC_W-1:0]   batch_size;
      logic [DIST_W-1:0] threshold;
      logic [DEB_W-1:0]  debounce_need;
      logic [DIST_W-1:0] batch [MAX_SAMPLES];
      logic [2:0]        held;
      bit                started;
      bit                stable;
      bit                pending;
      logic [DEB_W-1:0]  pending_run;
      rsp_type           expected_readings [$];
      int                errors;

      function void reset_state();
         batch_size    = 3'd3;
         threshold     = 15'd800;
         debounce_need = 8'd3;
         foreach (batch[i]) batch[i] = '0;
         held          = '0;
         started       = 1'b0;
         stable        = 1'b0;
         pending       = 1'b0;
         pending_run   = '0;
         errors        = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_MEDIAN_COUNT:   batch_size    = data[MC_W-1:0];
            REG_THRESHOLD_Q4:   threshold     = data[DIST_W-1:0];
            REG_DEBOUNCE_COUNT: debounce_need = data[DEB_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [DIST_W-1:0] echo_to_distance(logic [US_W-1:0] us);
         logic [31:0] prod;
         if (us == '0) return TIMEOUT_Q4;
         prod = 32'(us) * 32'(DIST_SCALE);
         return prod[30:16];
      endfunction

      // Counting debouncer: the stable state follows raw once it has held long enough
      function bit debounce_step(bit raw);
         if (debounce_need <= 8'd1 || !started) begin
            started     = 1'b1;
            stable      = raw;
            pending     = raw;
            pending_run = '0;
            return stable;
         end
         if (raw == stable) begin
            pending     = raw;
            pending_run = '0;
            return stable;
         end
         if (raw != pending) begin
            pending     = raw;
            pending_run = 8'd1;
         end else if (pending_run < debounce_need) begin
            pending_run++;
         end
         if (pending_run >= debounce_need) begin
            stable      = raw;
            pending_run = '0;
         end
         return stable;
      endfunction

      function logic [DIST_W-1:0] batch_median(int n);
         logic [DIST_W-1:0] sorted [MAX_SAMPLES];
         logic [DIST_W-1:0] t;
         int j;
         for (int i = 0; i < n; i++) sorted[i] = batch[i];
         for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0 && sorted[j] < sorted[j-1]) begin
               t           = sorted[j];
               sorted[j]   = sorted[j-1];
               sorted[j-1] = t;
               j--;
            end
         end
         return sorted[n/2];
      endfunction

      // Advance the shadow state by one accepted word; queue a reading if one is due
      function void note_word(req_type w);
         logic [DIST_W-1:0] distance;
         logic [DIST_W-1:0] med;
         int                n;
         bit                raw;
         rsp_type           r;
         if (w.command == CMD_RESTART) begin
            held    = '0;
            started = 1'b0;
            return;
         end
         distance = echo_to_distance(w.echo_us);
         n    = (batch_size > MAX_SAMPLES) ? MAX_SAMPLES : int'(batch_size);
         if (n <= 1) begin
            held = '0;
            med  = distance;
         end else begin
            if (held >= MAX_SAMPLES) held = '0;
            batch[held] = distance;
            held++;
            if (int'(held) < n) return;
            med  = batch_median(int'(held));
            held = '0;
         end
         raw               = (med != '0) && (med < threshold);
         r.distance_q4     = med;
         r.raw_occupied    = raw;
         r.stable_occupied = debounce_step(raw);
         expected_readings.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (expected_readings.size() == 0) begin
            report($sformatf("unexpected reading dist=%0d raw=%0b stable=%0b",
                             got.distance_q4, got.raw_occupied, got.stable_occupied));
            return;
         end
         want = expected_readings.pop_front();
         if (got.distance_q4 !== want.distance_q4)
            report($sformatf("distance_q4 got %0d want %0d", got.distance_q4, want.distance_q4));
         if (got.raw_occupied !== want.raw_occupied)
            report($sformatf("raw_occupied got %0b want %0b (dist %0d)",
                             got.raw_occupied, want.raw_occupied, want.distance_q4));
         if (got.stable_occupied !== want.stable_occupied)
            report($sformatf("stable_occupied got %0b want %0b (dist %0d)",
                             got.stable_occupied, want.stable_occupied, want.distance_q4));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   occupancy_scoreboard sb = new;
   bit  no_idle    = 1'b0;   // set for phases that run back to back with no gaps
   bit  near_below = 1'b0;   // which side of the threshold the current streak favors
   int  words_sent = 0;
   int  stall_left = 0;
   int  cycle_count = 0;

   echo_median_occupancy_debounce i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Sample both handshakes at the rising edge; the shadow model advances on accept
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_word(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_data);
   end

   // Receiver: drop ready for random stretches, hold it high during no-idle phases
   always @(negedge clock) begin
      if (no_idle) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run if the stimulus or the drain hangs
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Present one word at the falling edge and hold it until it is taken
   task automatic send_word(req_type w);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_echo(logic [US_W-1:0] us);
      req_type w;
      w.command = CMD_SAMPLE;
      w.echo_us = us;
      send_word(w);
   endtask

   task automatic send_restart(logic [US_W-1:0] us);
      req_type w;
      w.command = CMD_RESTART;
      w.echo_us = us;
      send_word(w);
   endtask

   // Stop sending, wait for every expected reading, then let the pipeline empty
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.set_register(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Pick a new setting for a random subset of the registers, extremes included
   task automatic configure_phase();
      logic [2:0]            which;
      logic [CSR_DATA_W-1:0] data;
      int                    r;
      which = 3'($urandom_range(1, 7));
      if (which[0]) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       data = 15'd0;
            1:       data = 15'd1;
            2:       data = 15'd5;
            3:       data = 15'($urandom_range(6, 7));
            default: data = 15'($urandom_range(2, 5));
         endcase
         // upper bits beyond the register width must be dropped
         if ($urandom_range(0, 7) == 0) data[CSR_DATA_W-1:MC_W] = 12'($urandom);
         write_reg(REG_MEDIAN_COUNT, data);
      end
      if (which[1]) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       data = 15'd0;
            1:       data = 15'd17983;
            2:       data = 15'($urandom_range(15984, 15985));
            3:       data = 15'd1;
            default: data = 15'($urandom_range(100, 4000));
         endcase
         write_reg(REG_THRESHOLD_Q4, data);
      end
      if (which[2]) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       data = 15'd0;
            1:       data = 15'd1;
            2:       data = 15'd255;
            3:       data = 15'($urandom_range(0, 255));
            default: data = 15'($urandom_range(2, 5));
         endcase
         if ($urandom_range(0, 7) == 0) data[CSR_DATA_W-1:DEB_W] = 7'($urandom);
         write_reg(REG_DEBOUNCE_COUNT, data);
      end
   endtask

   // One random word; streaks on one side of the threshold drive the debouncer
   task automatic send_random_word();
      int r;
      int base;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 5) == 0) near_below = !near_below;
      if (r < 6) begin
         send_restart(16'($urandom));
      end else if (r < 12) begin
         send_echo(16'd0);
      end else if (r < 18) begin
         send_echo(16'($urandom_range(1, 4)));
      end else if (r < 55) begin
         // aim near the threshold: us = threshold * 65536 / 17983
         base = (int'(sb.threshold) * 65536) / DIST_SCALE;
         base = near_below ? base - $urandom_range(0, 60) : base + $urandom_range(0, 60);
         if (base < 0) base = 0;
         if (base > 65535) base = 65535;
         send_echo(16'(base));
      end else if (r < 60) begin
         send_echo(16'($urandom_range(65500, 65535)));
      end else begin
         send_echo(16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      sb.reset_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting: batches of three, threshold 800, debounce 3.
      // Timeout, longest echo and a zero distance; the first reading sets the state.
      send_echo(16'd0);
      send_echo(16'hFFFF);
      send_echo(16'd1);
      // an occupied batch starts a pending change
      send_echo(16'd2000);
      send_echo(16'd2500);
      send_echo(16'd3000);
      // restart drops a partial batch; its echo field is ignored
      send_restart(16'hFFFF);
      send_echo(16'h5555);
      send_restart(16'hAAAA);
      quiesce();

      // pass-through with the widest threshold and no debounce
      write_reg(REG_MEDIAN_COUNT, 15'd0);
      write_reg(REG_THRESHOLD_Q4, 15'd17983);
      write_reg(REG_DEBOUNCE_COUNT, 15'd0);
      send_echo(16'hFFFF);
      send_echo(16'hFFFE);
      send_echo(16'd3);
      send_echo(16'd0);
      quiesce();

      // zero threshold: nothing is ever occupied; debounce at its maximum
      write_reg(REG_THRESHOLD_Q4, 15'd0);
      write_reg(REG_DEBOUNCE_COUNT, 15'd255);
      write_reg(REG_MEDIAN_COUNT, 15'd1);
      send_echo(16'd100);
      send_echo(16'd0);
      quiesce();

      // open a batch of five, then lower the count mid-batch
      write_reg(REG_THRESHOLD_Q4, 15'd800);
      write_reg(REG_DEBOUNCE_COUNT, 15'd2);
      write_reg(REG_MEDIAN_COUNT, 15'd5);
      send_echo(16'd1000);
      send_echo(16'd1200);
      send_echo(16'd3000);
      quiesce();
      write_reg(REG_MEDIAN_COUNT, 15'd2);
      send_echo(16'd500);
      quiesce();

      // count above the store acts as five; median lands exactly on the threshold
      write_reg(REG_MEDIAN_COUNT, 15'd7);
      write_reg(REG_DEBOUNCE_COUNT, 15'd1);
      send_echo(16'd4000);
      send_echo(16'd100);
      send_echo(16'd2916);
      send_echo(16'd2900);
      send_echo(16'd0);
      quiesce();

      // random phases, each under a fresh setting written while idle
      while (words_sent < TARGET_WORDS) begin
         configure_phase();
         no_idle = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(20, 80)) send_random_word();
         quiesce();
         no_idle = 1'b0;
      end

      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
